// ----- rtl/chkv_pkg.sv -----
// Package for the chained hash key-value table.
// Holds sizes, beat types, operation and status codes and controller commands.
// No dependencies.
package chkv_pkg;

  localparam int unsigned BUCKETS = 7;
  localparam int unsigned SLOTS   = 8;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned ValW    = 32;
  localparam int unsigned BktW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned SlotW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned FillW   = $clog2(SLOTS + 1);

  // key mod BUCKETS: quotient estimate by reciprocal, at most one short
  localparam int unsigned RecipShift = $clog2(BUCKETS) - 1;
  localparam int unsigned MulShift   = KeyW + RecipShift;
  localparam int unsigned QuotW      = 2 * KeyW - MulShift;
  localparam logic [KeyW-1:0] RecipM = KeyW'((64'd1 << MulShift) / BUCKETS);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]      op;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [ValW-1:0] value_out;
  } rsp_t;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } entry_t;

  typedef entry_t [SLOTS-1:0] row_t;

  // one step of the datapath per field
  typedef struct packed {
    logic load;
    logic mul;
    logic qb;
    logic red;
    logic rd;
    logic exe;
  } cmd_t;

endpackage

// ----- rtl/chkv_ctrl.sv -----
// Controller of the chained hash key-value table.
// One-hot sequencer issuing datapath commands; uses chkv_pkg.
module chkv_ctrl
  import chkv_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  output cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_QB   = 6'b000100,
    S_RED  = 6'b001000,
    S_RD   = 6'b010000,
    S_EXE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start) state_d = S_MUL;
      S_MUL:   state_d = S_QB;
      S_QB:    state_d = S_RED;
      S_RED:   state_d = S_RD;
      S_RD:    state_d = S_EXE;
      S_EXE:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy       = (state_q != S_IDLE);
  assign cmd_o.load = start && (state_q == S_IDLE);
  assign cmd_o.mul  = (state_q == S_MUL);
  assign cmd_o.qb   = (state_q == S_QB);
  assign cmd_o.red  = (state_q == S_RED);
  assign cmd_o.rd   = (state_q == S_RD);
  assign cmd_o.exe  = (state_q == S_EXE);

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state register not one-hot");
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_MUL) ##4 (state_q == S_EXE))
    else $error("accepted beat did not run the full sequence");

endmodule

// ----- rtl/chkv_dp.sv -----
// Datapath of the chained hash key-value table: modulo unit, bucket row
// memory, fill counts, match and row rewrite, result register. Uses chkv_pkg.
module chkv_dp
  import chkv_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  req_t               req_q;
  logic [2*KeyW-1:0]  prod_q;
  logic [KeyW-1:0]    qb_q;
  logic [BktW-1:0]    bucket_q;
  logic [FillW-1:0]   fill_q [BUCKETS];
  row_t               mem [BUCKETS];
  row_t               row_q;
  rsp_t               rsp_q;
  logic               done_q;

  logic [QuotW-1:0]   quot;
  logic [KeyW-1:0]    diff;
  logic [FillW-1:0]   fill_cur;
  logic [SLOTS-1:0]   hits;
  logic [SlotW-1:0]   hit_idx;
  logic               found;
  row_t               row_new;
  logic               wr_en;
  logic [FillW-1:0]   fill_new;
  rsp_t               rsp_d;
  entry_t             ins;

  assign quot = prod_q[2*KeyW-1:MulShift];
  assign diff = req_q.key - qb_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.mul) prod_q <= (2*KeyW)'(req_q.key) * (2*KeyW)'(RecipM);
    if (cmd_i.qb) qb_q <= KeyW'(KeyW'(quot) * KeyW'(BUCKETS));
    if (cmd_i.red) begin
      bucket_q <= (diff >= KeyW'(BUCKETS)) ? BktW'(diff - KeyW'(BUCKETS)) : BktW'(diff);
    end
    if (cmd_i.rd) row_q <= mem[bucket_q];
    if (wr_en) mem[bucket_q] <= row_new;
    if (cmd_i.exe) rsp_q <= rsp_d;
  end

  assign fill_cur = fill_q[bucket_q];
  assign ins      = '{key: req_q.key, value: req_q.value_in};

  always_comb begin
    hits    = '0;
    hit_idx = '0;
    for (int s = 0; s < SLOTS; s++) begin
      hits[s] = (FillW'(s) < fill_cur) && (row_q[s].key == req_q.key);
    end
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (hits[s]) hit_idx = SlotW'(s);
    end
    found = |hits;
  end

  always_comb begin
    row_new  = row_q;
    wr_en    = 1'b0;
    fill_new = fill_cur;
    rsp_d    = '{status: ST_OK, value_out: '0};
    case (req_q.op)
      OP_INSERT: begin
        if (fill_cur >= FillW'(SLOTS)) begin
          rsp_d.status = ST_FULL;
        end else begin
          for (int s = 0; s < SLOTS; s++) begin
            if (FillW'(s) == fill_cur) row_new[s] = ins;
          end
          wr_en    = cmd_i.exe;
          fill_new = fill_cur + FillW'(1);
        end
      end
      OP_DELETE, OP_SEARCH: begin
        if (!found) begin
          rsp_d.status = ST_MISSING;
        end else begin
          rsp_d.value_out = row_q[hit_idx].value;
          if (req_q.op == OP_DELETE) begin
            for (int s = 0; s < SLOTS - 1; s++) begin
              if (SlotW'(s) >= hit_idx) row_new[s] = row_q[s+1];
            end
            wr_en    = cmd_i.exe;
            fill_new = fill_cur - FillW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < BUCKETS; b++) fill_q[b] <= '0;
      done_q <= 1'b0;
    end else begin
      if (wr_en) fill_q[bucket_q] <= fill_new;
      done_q <= cmd_i.exe;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_bucket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd |-> (bucket_q < BktW'(BUCKETS)))
    else $error("bucket index out of range");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exe |-> (fill_cur <= FillW'(SLOTS)))
    else $error("bucket fill count beyond slot count");
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status != ST_OK) |-> (rsp_o.value_out == '0))
    else $error("non-zero value on failed operation");

endmodule

// ----- rtl/chained_hash_key_value_table_top.sv -----
// Top level of the chained hash key-value table.
// Joins chkv_ctrl and chkv_dp; uses chkv_pkg.
//
// A beat is taken when start is high and busy is low. Its result appears on
// rsp_o with done_o high for one cycle, and busy falls in that same cycle, so
// a new beat is taken only once the last one has its result. Each beat runs
// through the key modulo unit (reciprocal multiply, quotient-by-bucket
// multiply, correcting subtract) and the registered read of the bucket row
// before it is matched and written back. The receiver cannot stall: done_o
// must be sampled in the cycle it is high. There is no clearing pass after
// reset; fill counts clear at once.
module chained_hash_key_value_table_top
  import chkv_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  cmd_t cmd;

  chkv_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  chkv_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

// ----- tb/sv/chained_hash_key_value_table_top_tb.sv -----
// Self-checking testbench for chained_hash_key_value_table_top.
// Keeps its own bucket/slot image to predict each result beat; uses chkv_pkg.
// Directed cases first, then random insert/delete/search traffic with random gaps.
module chained_hash_key_value_table_top_tb;
  import chkv_pkg::*;

  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned POOL_SIZE    = 24;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  rsp_t rsp_o;

  chained_hash_key_value_table_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // table image
  bit [KeyW-1:0] tbl_key [BUCKETS][SLOTS];
  bit [ValW-1:0] tbl_val [BUCKETS][SLOTS];
  int unsigned   tbl_fill [BUCKETS];

  rsp_t          pending_rsp_q [$];
  bit [KeyW-1:0] key_pool [POOL_SIZE];
  int unsigned   errors;
  int unsigned   cycles;
  int unsigned   beats;
  int unsigned   n_insert;
  int unsigned   n_full;
  int unsigned   n_hit;
  int unsigned   n_miss;
  int unsigned   max_gap;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  function automatic rsp_t table_apply(req_t r);
    rsp_t        o;
    int unsigned b;
    int unsigned n;
    int unsigned hit;
    o.status    = ST_OK;
    o.value_out = '0;
    b   = r.key % BUCKETS;
    n   = tbl_fill[b];
    hit = SLOTS;
    case (r.op)
      OP_INSERT: begin
        n_insert++;
        if (n >= SLOTS) begin
          o.status = ST_FULL;
          n_full++;
        end else begin
          tbl_key[b][n] = r.key;
          tbl_val[b][n] = r.value_in;
          tbl_fill[b]   = n + 1;
        end
      end
      OP_DELETE, OP_SEARCH: begin
        for (int i = 0; i < n; i++) begin
          if (hit == SLOTS && tbl_key[b][i] == r.key) hit = i;
        end
        if (hit == SLOTS) begin
          o.status = ST_MISSING;
          n_miss++;
        end else begin
          o.value_out = tbl_val[b][hit];
          n_hit++;
          if (r.op == OP_DELETE) begin
            for (int s = hit; s + 1 < n; s++) begin
              tbl_key[b][s] = tbl_key[b][s+1];
              tbl_val[b][s] = tbl_val[b][s+1];
            end
            tbl_fill[b] = n - 1;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // result check first, then capture of the beat taken at the same edge
  always @(posedge clk_i) begin : result_monitor
    rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_rsp_q.size() == 0) begin
          $error("result beat with nothing outstanding: status %0d value_out %h",
                 rsp_o.status, rsp_o.value_out);
          errors++;
        end else begin
          want = pending_rsp_q.pop_front();
          if (rsp_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_o.status);
            errors++;
          end
          if (rsp_o.value_out !== want.value_out) begin
            $error("value_out: expected %h, got %h", want.value_out, rsp_o.value_out);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        pending_rsp_q = {pending_rsp_q, table_apply(req_i)};
        beats++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // entered and left at a falling edge
  task automatic send_beat(logic [1:0] op, logic [KeyW-1:0] key, logic [ValW-1:0] val);
    req_t        item;
    int unsigned gap;
    item.op       = op;
    item.key      = key;
    item.value_in = val;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= item;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  function automatic logic [KeyW-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 80) return key_pool[$urandom_range(0, POOL_SIZE - 1)] + 7 * $urandom_range(1, 3);
    return $urandom;
  endfunction

  task automatic run_random(int unsigned count, int unsigned w_ins, int unsigned w_del);
    int unsigned r;
    logic [1:0]  op;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < w_ins) op = OP_INSERT;
      else if (r < w_ins + w_del) op = OP_DELETE;
      else if (r < 96) op = OP_SEARCH;
      else op = OP_UNUSED;
      send_beat(op, pick_key(), $urandom);
    end
  endtask

  task automatic test_extremes();
    max_gap = 13;
    send_beat(OP_INSERT, '0, '0);
    send_beat(OP_INSERT, '1, '1);
    send_beat(OP_SEARCH, '0, '1);
    send_beat(OP_SEARCH, '1, '0);
    send_beat(OP_UNUSED, '1, '1);
    send_beat(OP_DELETE, '1, 32'h5a5a_a5a5);
    send_beat(OP_SEARCH, '1, '0);
    send_beat(OP_DELETE, 32'd7, '0);
  endtask

  // bucket 3 filled to the brim, duplicates and mid-chain removal
  task automatic test_full_bucket();
    max_gap = 0;
    send_beat(OP_INSERT, 32'd3,  32'h1111_0001);
    send_beat(OP_INSERT, 32'd10, 32'h1111_0002);
    send_beat(OP_INSERT, 32'd3,  32'h1111_0003);
    send_beat(OP_INSERT, 32'd17, 32'h1111_0004);
    send_beat(OP_INSERT, 32'd24, 32'h1111_0005);
    send_beat(OP_INSERT, 32'd3,  32'h1111_0006);
    send_beat(OP_INSERT, 32'd31, 32'h1111_0007);
    send_beat(OP_INSERT, 32'd38, 32'h1111_0008);
    send_beat(OP_INSERT, 32'd45, 32'hdead_beef);
    send_beat(OP_SEARCH, 32'd3,  '0);
    send_beat(OP_DELETE, 32'd3,  '0);
    send_beat(OP_SEARCH, 32'd3,  '0);
    send_beat(OP_DELETE, 32'd24, '0);
    send_beat(OP_SEARCH, 32'd38, '0);
    send_beat(OP_SEARCH, 32'd52, '0);
  endtask

  task automatic test_random_growth();
    max_gap = 13;
    run_random(300, 50, 20);
  endtask

  task automatic test_random_back_to_back();
    max_gap = 0;
    run_random(200, 35, 30);
  endtask

  task automatic test_random_drain();
    max_gap = 13;
    run_random(250, 20, 45);
  endtask

  task automatic test_random_short_gaps();
    max_gap = 3;
    run_random(200, 40, 30);
  endtask

  initial begin
    rst_ni  = 1'b0;
    start   = 1'b0;
    req_i   = '0;
    max_gap = 0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'd7;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_extremes();
    test_full_bucket();
    test_random_growth();
    test_random_back_to_back();
    test_random_drain();
    test_random_short_gaps();

    start <= 1'b0;
    wait (pending_rsp_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d beats in %0d cycles: %0d inserts (%0d to a full bucket)",
             beats, cycles, n_insert, n_full);
    $display("lookups and deletes: %0d hits, %0d misses; %0d mismatches",
             n_hit, n_miss, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
